// ===== rtl/pat_pkg.sv =====
// shared types and constants for the peer address table
`timescale 1ns / 1ps
package pat_pkg;
  localparam int PEERS = 16;
  localparam int ID_BYTES = 8;
  localparam int IDX_W = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int CNT_W = $clog2(PEERS + 1);
  localparam logic [63:0] ID_MASK = (ID_BYTES >= 8) ? 64'hFFFF_FFFF_FFFF_FFFF :
      ((64'd1 << (8 * ID_BYTES)) - 64'd1);

  localparam logic [1:0] MODE_LEARN4 = 2'd0;
  localparam logic [1:0] MODE_LEARN6 = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] user_id;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [31:0] now_time;
    logic [3:0]  entry_index;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [63:0] read_id;
    logic [31:0] read_addr4;
    logic [63:0] read_addr6_hi;
    logic [63:0] read_addr6_lo;
    logic [31:0] read_seen4;
    logic [31:0] read_seen6;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DROP, ST_WRITE, ST_CLEAR, ST_READ, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic drop;
    logic write;
    logic clear;
    logic read;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } sts_t;
endpackage

// ===== rtl/pat_if.sv =====
// valid/ready channel interfaces
`timescale 1ns / 1ps
interface pat_in_if;
  logic valid;
  logic ready;
  pat_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pat_out_if;
  logic valid;
  logic ready;
  pat_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/pat_ctrl.sv =====
// controller state machine of the peer address table
`timescale 1ns / 1ps
module pat_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      in_mode,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output pat_pkg::cmd_t   cmd,
  input  pat_pkg::sts_t   sts
);
  pat_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pat_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      pat_pkg::ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load = 1'b1;
          case (in_mode)
            pat_pkg::MODE_CLEAR: state_next = pat_pkg::ST_CLEAR;
            pat_pkg::MODE_READ: state_next = pat_pkg::ST_READ;
            default: begin
              cmd.scan_start = 1'b1;
              state_next = pat_pkg::ST_SCAN;
            end
          endcase
        end
      end
      pat_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_next = pat_pkg::ST_DROP;
      end
      pat_pkg::ST_DROP: begin
        cmd.drop = 1'b1;
        state_next = pat_pkg::ST_WRITE;
      end
      pat_pkg::ST_WRITE: begin
        cmd.write = 1'b1;
        state_next = pat_pkg::ST_OUT;
      end
      pat_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        state_next = pat_pkg::ST_OUT;
      end
      pat_pkg::ST_READ: begin
        cmd.read = 1'b1;
        state_next = pat_pkg::ST_OUT;
      end
      pat_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = pat_pkg::ST_IDLE;
      end
      default: state_next = pat_pkg::ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/pat_dp.sv =====
// table storage, scan and update datapath
`timescale 1ns / 1ps
module pat_dp (
  input  logic               clk,
  input  logic               rst,
  input  pat_pkg::cmd_t      cmd,
  output pat_pkg::sts_t      sts,
  input  pat_pkg::in_word_t  in_data,
  output pat_pkg::out_word_t out_data
);
  localparam int N = pat_pkg::PEERS;
  localparam int IW = pat_pkg::IDX_W;
  localparam int CW = pat_pkg::CNT_W;

  logic [63:0] ids [N];
  logic [31:0] a4 [N];
  logic [63:0] a6h [N];
  logic [63:0] a6l [N];
  logic [31:0] s4 [N];
  logic [31:0] s6 [N];

  pat_pkg::in_word_t req;
  logic [CW-1:0] cnt;
  logic has_id, has_addr, has_free;
  logic [IW-1:0] by_id, by_addr, free_slot;
  logic [IW-1:0] k;
  logic [IW-1:0] ri;
  logic v6;
  logic [63:0] rid;
  logic id_hit, addr_hit;
  logic same;

  assign v6 = (req.mode == pat_pkg::MODE_LEARN6);
  assign k = cnt[IW-1:0];
  assign ri = req.entry_index[IW-1:0];
  assign rid = req.user_id & pat_pkg::ID_MASK;
  assign id_hit = (ids[k] == rid);
  assign addr_hit = v6 ? (a6h[k] == req.addr_hi && a6l[k] == req.addr_lo)
                       : (a4[k] == req.addr_lo[31:0]);
  assign sts.scan_done = (cnt == CW'(N - 1));
  assign same = has_addr && has_id && (by_addr == by_id);

  always_ff @(posedge clk) begin
    if (cmd.load) req <= in_data;
    if (cmd.scan_start) begin
      cnt <= '0;
      has_id <= 1'b0;
      has_addr <= 1'b0;
      has_free <= 1'b0;
    end else if (cmd.scan_step) begin
      cnt <= cnt + CW'(1);
      if (ids[k] == 64'd0) begin
        if (!has_free) begin
          has_free <= 1'b1;
          free_slot <= k;
        end
      end else begin
        if (id_hit) begin
          has_id <= 1'b1;
          by_id <= k;
        end
        if (addr_hit) begin
          has_addr <= 1'b1;
          by_addr <= k;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < N; i++) begin
        ids[i] <= '0; a4[i] <= '0; a6h[i] <= '0;
        a6l[i] <= '0; s4[i] <= '0; s6[i] <= '0;
      end
    end else if (cmd.drop) begin
      if (has_addr && !same) begin
        if (v6) begin
          a6h[by_addr] <= '0; a6l[by_addr] <= '0; s6[by_addr] <= '0;
          if (s4[by_addr] == 32'd0) begin
            ids[by_addr] <= '0; a4[by_addr] <= '0;
          end
        end else begin
          a4[by_addr] <= '0; s4[by_addr] <= '0;
          if (s6[by_addr] == 32'd0) begin
            ids[by_addr] <= '0; a6h[by_addr] <= '0; a6l[by_addr] <= '0;
          end
        end
      end
    end else if (cmd.write) begin
      if (has_id) begin
        if (v6) begin
          a6h[by_id] <= req.addr_hi; a6l[by_id] <= req.addr_lo;
          s6[by_id] <= req.now_time;
        end else begin
          a4[by_id] <= req.addr_lo[31:0]; s4[by_id] <= req.now_time;
        end
      end else if (has_free) begin
        if (req.now_time == 32'd0) begin
          ids[free_slot] <= '0; a4[free_slot] <= '0; a6h[free_slot] <= '0;
          a6l[free_slot] <= '0; s4[free_slot] <= '0; s6[free_slot] <= '0;
        end else begin
          ids[free_slot] <= rid;
          if (v6) begin
            a6h[free_slot] <= req.addr_hi; a6l[free_slot] <= req.addr_lo;
            s6[free_slot] <= req.now_time; a4[free_slot] <= '0; s4[free_slot] <= '0;
          end else begin
            a4[free_slot] <= req.addr_lo[31:0]; s4[free_slot] <= req.now_time;
            a6h[free_slot] <= '0; a6l[free_slot] <= '0; s6[free_slot] <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      out_data <= '{status: !has_id && !has_free, default: '0};
    end else if (cmd.clear) begin
      out_data <= '0;
    end else if (cmd.read) begin
      if ({1'b0, req.entry_index} < 5'(N)) begin
        out_data <= '{status: 1'b0, read_id: ids[ri], read_addr4: a4[ri],
                      read_addr6_hi: a6h[ri], read_addr6_lo: a6l[ri],
                      read_seen4: s4[ri], read_seen6: s6[ri]};
      end else begin
        out_data <= '0;
      end
    end
  end
endmodule

// ===== rtl/peer_address_table.sv =====
// peer address table top level
// One word at a time: a learn passes through the accept state, a scan of the
// table entries, a drop and a write state, then the result state; a clear or
// a read passes through the accept state, its own state and the result state.
// The scan of all 16 entries, one per cycle, sets the learn time. The result
// is held until taken; the next word is accepted in the cycle after.
`timescale 1ns / 1ps
module peer_address_table (
  input  logic clk,
  input  logic rst,
  pat_in_if.sink    in_ch,
  pat_out_if.source out_ch
);
  pat_pkg::cmd_t cmd;
  pat_pkg::sts_t sts;

  pat_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_mode(in_ch.data.mode), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .sts(sts)
  );

  pat_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_data(in_ch.data), .out_data(out_ch.data)
  );
endmodule
